// ===== hw/rtl/ita_pkg.sv =====
// Package for the integer to radix ASCII unit.
// Holds shared constants, control structs, the sequencer state type and the digit map.
// No dependencies.
`default_nettype none

package ita_pkg;

  localparam int WORD_BITS_DEF  = 32;
  localparam int MAX_DIGITS_DEF = 32;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER  = 8'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } ita_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_TEN) begin
      res = CHAR_ZERO + {2'b00, d};
    end else begin
      res = CHAR_LOWER + {2'b00, d - DIGIT_TEN};
    end
    return res;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ita_intf.sv =====
// Handshake channels of the integer to radix ASCII unit: input value, radix write, output char.
// Depends on ita_pkg.
`default_nettype none

interface ita_value_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ita_cfg_if
  import ita_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

interface ita_char_if
  import ita_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ita_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module ita_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ita_divider.sv =====
// Bit-serial restoring divider: WORD_BITS-bit dividend by a 6-bit radix, one bit per cycle.
// Depends on ita_pkg.
`default_nettype none

module ita_divider import ita_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire div_ctrl_t            ctrl_i,
  input  wire logic [WORD_BITS-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]   divisor_i,
  output      div_stat_t            stat_o,
  output      logic [WORD_BITS-1:0] quotient_o,
  output      logic [DIGIT_W-1:0]   remainder_o
);

  localparam int CNT_W = $clog2(WORD_BITS);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [WORD_BITS-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [RADIX_W-1:0]   div_q, div_d;
  logic [DIGIT_W:0]     trial;
  logic [DIGIT_W:0]     diff;
  logic                 ge;

  assign trial = {rem_q, quot_q[WORD_BITS-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[WORD_BITS-2:0], ge};
      rem_d  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quot_q;
  assign remainder_o  = rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_not_busy_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider busy while reporting done");

  a_remainder_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_radix_ascii_unit.sv =====
// Integer to radix ASCII unit: one signed value in, its text in the configured radix out.
// Each digit takes one full division; the stored digits are then read back and sent, after any minus sign.
// One item is converted at a time.
// The shared bit-serial divider sets the rate; input is not ready until the last char leaves.
// Reset: radix returns to 10, sequencer idle, no output pending; digit store is not cleared.
// Depends on ita_pkg, ita_intf, ita_ram and ita_divider.
`default_nettype none

module integer_to_radix_ascii_unit import ita_pkg::*; #(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  ita_value_if.sink  in_if,
  ita_cfg_if.sink    cfg_if,
  ita_char_if.source out_if
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  ita_state_e state_q, state_d;

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] eff_radix_q, eff_radix_d;
  logic               signed_q, signed_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      emit_q, emit_d;
  logic [CW-1:0]      count_inc;
  logic [CW-1:0]      limit;
  logic [CW-1:0]      rd_pos;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_sign_q, out_sign_d;

  logic [WORD_BITS-1:0] in_bits;
  logic [WORD_BITS-1:0] magnitude;
  logic                 in_neg;
  logic [RADIX_W-1:0]   in_radix;

  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [WORD_BITS-1:0] div_dividend;
  logic [WORD_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]   div_rem;

  logic                 ram_we;
  logic [DIGIT_W-1:0]   ram_rdata;

  assign in_bits   = in_if.value;
  assign in_neg    = in_bits[WORD_BITS-1];
  assign magnitude = in_neg ? (~in_bits + 1'b1) : in_bits;
  assign in_radix  = clamp_radix(radix_q);

  assign count_inc = count_q + 1'b1;
  assign limit     = signed_q ? CW'(MAX_DIGITS - 1) : CW'(MAX_DIGITS);
  assign rd_pos    = count_q - 1'b1 - emit_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_if.valid) begin
      radix_q <= cfg_if.radix;
    end
  end

  always_comb begin
    state_d          = state_q;
    eff_radix_d      = eff_radix_q;
    signed_d         = signed_q;
    count_d          = count_q;
    emit_d           = emit_q;
    out_valid_d      = out_valid_q;
    out_char_d       = out_char_q;
    out_last_d       = out_last_q;
    out_sign_d       = out_sign_q;
    div_ctrl.start   = 1'b0;
    div_dividend     = div_quot;
    ram_we           = 1'b0;
    in_if.ready      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          eff_radix_d    = in_radix;
          signed_d       = in_neg && (in_radix == RADIX_DEC);
          count_d        = '0;
          div_ctrl.start = 1'b1;
          div_dividend   = magnitude;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we  = 1'b1;
          count_d = count_inc;
          emit_d  = '0;
          if ((div_quot != '0) && (count_inc < limit)) begin
            div_ctrl.start = 1'b1;
          end else if (signed_q) begin
            out_valid_d = 1'b1;
            out_char_d  = CHAR_MINUS;
            out_last_d  = 1'b0;
            out_sign_d  = 1'b1;
            state_d     = ST_SEND;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        out_valid_d = 1'b1;
        out_char_d  = digit_char(ram_rdata);
        out_last_d  = (emit_q + 1'b1) == count_q;
        out_sign_d  = 1'b0;
        state_d     = ST_SEND;
      end
      ST_SEND: begin
        if (out_if.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            if (!out_sign_q) begin
              emit_d = emit_q + 1'b1;
            end
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
      signed_q    <= 1'b0;
      out_sign_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      signed_q    <= signed_d;
      out_sign_q  <= out_sign_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eff_radix_q <= eff_radix_d;
    out_char_q  <= out_char_d;
  end

  ita_divider #(
    .WORD_BITS (WORD_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (div_dividend),
    .divisor_i   (div_ctrl.start && (state_q == ST_IDLE) ? in_radix : eff_radix_q),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  ita_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (div_rem),
    .raddr_i (rd_pos[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_if.valid     = out_valid_q;
  assign out_if.text_char = out_char_q;
  assign out_if.last_char = out_last_q;

  a_no_input_while_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_if.ready)
    else $error("input ready while an item is pending at the output");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_done_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider result outside digit generation");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_if.ready && out_last_q) |=> (state_q == ST_IDLE))
    else $error("sequencer not idle after final char");

  a_emit_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (emit_q < count_q))
    else $error("read beyond generated digits");

endmodule

`default_nettype wire

// ===== tb/tb_integer_to_radix_ascii_unit.sv =====
// Testbench for integer_to_radix_ascii_unit: drives signed values and radix writes, predicts
// the ASCII text of each value and checks every char as it is sent, with random stalls.
// Depends on ita_pkg, ita_intf and the unit itself.
module tb_integer_to_radix_ascii_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  localparam int    HALF_PERIOD     = 5;
  localparam int    QUIET_LIMIT     = 20000;
  localparam int    HOLD_CYCLES     = 700;
  localparam int    ITEMS_PER_PHASE = 28;
  localparam int    RANDOM_PHASES   = 11;
  localparam int    HOLD_PHASE      = 4;
  localparam int    STEADY_PHASE    = 6;
  localparam int    IDLE_PERCENT    = 11;
  localparam string DIGIT_SET       = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } text_char_t;

  logic clk_i;
  logic rst_ni;

  ita_value_if #(.WORD_BITS(32)) value_ch ();
  ita_cfg_if                     cfg_ch ();
  ita_char_if                    char_ch ();

  integer_to_radix_ascii_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (value_ch),
    .cfg_if (cfg_ch),
    .out_if (char_ch)
  );

  logic signed [31:0] values_to_send [$];
  text_char_t         expected_chars [$];
  logic [RADIX_W-1:0] radix_shadow;
  logic               steady;
  logic               fired;
  int                 values_offered;
  int                 values_accepted;
  int                 chars_checked;
  int                 radix_writes;
  int                 error_count;
  int                 quiet_cycles;
  int                 holds_requested;
  int                 holds_done;
  int                 hold_left;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.radix = '0;
    char_ch.ready = 1'b0;
    radix_shadow = RADIX_RESET;
    steady = 1'b0;
    values_offered = 0;
    values_accepted = 0;
    chars_checked = 0;
    radix_writes = 0;
    error_count = 0;
    quiet_cycles = 0;
    holds_requested = 0;
    holds_done = 0;
    hold_left = 0;
  end

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [RADIX_W-1:0] effective_base(input logic [RADIX_W-1:0] r);
    return (r < RADIX_MIN) ? RADIX_MIN : ((r > RADIX_MAX) ? RADIX_MAX : r);
  endfunction

  // Queue the chars of one value in the current radix, most significant first.
  function automatic void predict_text(input logic [31:0] value);
    logic [RADIX_W-1:0] base;
    logic [31:0]        magnitude;
    logic [DIGIT_W-1:0] digits [32];
    logic               signed_text;
    int                 count;
    int                 limit;
    text_char_t         entry;
    base = effective_base(radix_shadow);
    magnitude = value[31] ? (~value + 32'd1) : value;
    signed_text = value[31] && (base == RADIX_DEC);
    limit = signed_text ? 31 : 32;
    count = 0;
    do begin
      digits[count] = DIGIT_W'(magnitude % base);
      magnitude = magnitude / base;
      count++;
    end while (magnitude != 0 && count < limit);
    if (signed_text) begin
      entry.text_char = CHAR_MINUS;
      entry.last_char = 1'b0;
      expected_chars.push_back(entry);
    end
    for (int i = count - 1; i >= 0; i--) begin
      entry.text_char = DIGIT_SET[digits[i]];
      entry.last_char = (i == 0);
      expected_chars.push_back(entry);
    end
  endfunction

  function automatic logic signed [31:0] random_value(input logic [RADIX_W-1:0] reg_radix);
    logic [31:0] base;
    logic [31:0] mag;
    int          kind;
    base = 32'(effective_base(reg_radix));
    kind = $urandom_range(0, 5);
    case (kind)
      0: begin
        mag = $urandom;
      end
      1: begin
        mag = $urandom_range(0, 99);
      end
      2: begin
        mag = 32'd1;
        repeat ($urandom_range(0, 31)) begin
          if (mag <= 32'h7fffffff / base) mag = mag * base;
        end
        mag = mag - $urandom_range(0, 1);
      end
      3: begin
        mag = $urandom >> $urandom_range(0, 31);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: mag = 32'h7fffffff;
          1: mag = 32'h80000000;
          2: mag = 32'hffffffff;
          default: mag = 32'h00000000;
        endcase
      end
    endcase
    if (kind >= 1 && kind <= 3 && $urandom_range(0, 1) == 1) mag = ~mag + 32'd1;
    return mag;
  endfunction

  // Sender: hold an offered item until taken, else offer the next one or idle.
  always @(negedge clk_i) begin
    if (!value_ch.valid || values_accepted == values_offered) begin
      if (rst_ni && values_to_send.size() > 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        value_ch.valid <= 1'b1;
        value_ch.value <= values_to_send.pop_front();
        values_offered++;
      end else begin
        value_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls except in the steady phase.
  always @(negedge clk_i) begin
    if (holds_done != holds_requested) begin
      holds_done = holds_requested;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      char_ch.ready <= 1'b0;
    end else begin
      char_ch.ready <= rst_ni && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      fired = 1'b0;
      if (value_ch.valid && value_ch.ready) begin
        predict_text(value_ch.value);
        values_accepted++;
        fired = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        radix_shadow = cfg_ch.radix;
        radix_writes++;
        fired = 1'b1;
      end
      if (char_ch.valid && char_ch.ready) begin
        fired = 1'b1;
        if (expected_chars.size() == 0) begin
          $error("unexpected char %h with no text pending", char_ch.text_char);
          error_count++;
        end else begin
          if (char_ch.text_char !== expected_chars[0].text_char) begin
            $error("text_char mismatch: expected %h actual %h",
                   expected_chars[0].text_char, char_ch.text_char);
            error_count++;
          end
          if (char_ch.last_char !== expected_chars[0].last_char) begin
            $error("last_char mismatch: expected %b actual %b",
                   expected_chars[0].last_char, char_ch.last_char);
            error_count++;
          end
          void'(expected_chars.pop_front());
        end
        chars_checked++;
      end
      quiet_cycles = fired ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_text();
    while (values_to_send.size() != 0 || values_accepted != values_offered ||
           expected_chars.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [RADIX_W-1:0] radix_plan [RANDOM_PHASES];
    radix_plan = '{6'd16, 6'd8, 6'd1, 6'd37, 6'd10, 6'd3, 6'd36, 6'd2, 6'd10, 6'd7, 6'd5};
    radix_plan[9] = RADIX_W'($urandom_range(0, 63));
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // radix 10 out of reset: sign, zero, extremes
    values_to_send = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
                       32'h7fffffff, 32'h80000000, 32'sd1234567890, -32'sd987654321};
    wait_for_text();
    write_radix(RADIX_MAX);
    values_to_send = '{32'sd35, 32'sd36, -32'sd36, 32'sd60466175,
                       32'h7fffffff, 32'h80000000};
    wait_for_text();
    write_radix(RADIX_MIN);
    values_to_send = '{32'sd0, -32'sd1, 32'h80000000, 32'h7fffffff, 32'h55555555};
    wait_for_text();
    // out-of-range radix saturates to the nearest legal one
    write_radix(6'd0);
    values_to_send = '{32'sd5, -32'sd5};
    wait_for_text();
    write_radix(6'd63);
    values_to_send = '{32'sd35, -32'sd71};
    wait_for_text();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_radix(radix_plan[p]);
      steady = (p == STEADY_PHASE);
      if (p == HOLD_PHASE) holds_requested++;
      repeat (ITEMS_PER_PHASE) values_to_send.push_back(random_value(radix_plan[p]));
      wait_for_text();
    end
    steady = 1'b0;

    repeat (100) @(posedge clk_i);
    $display("Converted %0d values over %0d radix writes, %0d chars checked.",
             values_accepted, radix_writes, chars_checked);
    $display("Radix settings included 0, 1, 2, 10, 36, 37 and 63; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ita_pkg.sv
hw/rtl/ita_intf.sv
hw/rtl/ita_ram.sv
hw/rtl/ita_divider.sv
hw/rtl/integer_to_radix_ascii_unit.sv
tb/tb_integer_to_radix_ascii_unit.sv
